>>> sv/b64d_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the alphabet lookup of the base64 stream decoder.
package b64d_pkg;

  localparam int unsigned CountBitsDefault = 21;
  localparam int unsigned CapacityW        = 20;
  localparam int unsigned CharCountW       = 21;
  localparam int unsigned GroupW           = 24;
  localparam int unsigned QueueDepth       = 4;
  localparam logic [CapacityW-1:0] CapacityReset = '1;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // One unit of work for the back end: either a full group of three bytes
  // or a single status word.
  typedef struct packed {
    logic                  is_group;
    kind_e                 kind;
    logic [GroupW-1:0]     group;
    logic [CharCountW-1:0] count;
  } job_t;

  // Bit 6 set marks a character of the alphabet; bits 5:0 hold its value.
  function automatic logic [6:0] sym_lookup(logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'h3E};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'h3F};
    end else if (c == 8'h3D) begin
      r = {1'b1, 6'h00};
    end
    return r;
  endfunction

endpackage

>>> sv/base64_stream_decoder_top.sv
`timescale 1ns / 1ps
// Top level of the base64 stream decoder.
// The decoder takes one character word per cycle on the slave side, with no
// stall of its own as long as the output keeps up; a word with tlast set
// closes the text. Each fourth significant character yields three byte words
// and each end of text or error yields one status word. The front end
// accepts a character and writes a job into a four-entry queue;
// the back end drains that queue one output word per handshake, so a three-byte
// group occupies it for three output words. The input stalls only when
// the queue is full. The output capacity register may be written at any time
// while no text is being decoded.
module base64_stream_decoder_top
  import b64d_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CapacityW-1:0] cfg_data_i,      // out_capacity
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,    // char_code
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,    // data_byte, char_count, zero fill
  output logic [1:0]           m_axis_tuser,    // kind
  output logic                 m_axis_tlast
);

  logic in_fire;
  logic push;
  job_t push_job;
  logic full;
  logic pop;
  logic avail;
  job_t head;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  b64d_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_fire_i    (in_fire),
    .char_code_i  (s_axis_tdata),
    .end_of_text_i(s_axis_tlast),
    .push_o       (push),
    .push_job_o   (push_job)
  );

  b64d_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .full_o    (full),
    .pop_i     (pop),
    .avail_o   (avail),
    .head_o    (head)
  );

  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (avail),
    .head_i       (head),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

>>> sv/b64d_front.sv
`timescale 1ns / 1ps
// Front end: accepts characters, keeps the per-text state and queues jobs.
module b64d_front
  import b64d_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CapacityW-1:0] cfg_data_i,
  input  logic                 in_fire_i,
  input  logic [7:0]           char_code_i,
  input  logic                 end_of_text_i,
  output logic                 push_o,
  output job_t                 push_job_o
);

  localparam int unsigned CmpW = ((COUNT_BITS > CapacityW) ? COUNT_BITS : CapacityW) + 1;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  logic [CapacityW-1:0]  cap_q;
  logic [GroupW-1:0]     acc_q, acc_d;
  logic [1:0]            pos_q, pos_d;
  logic [COUNT_BITS-1:0] bw_q, bw_d;
  logic [COUNT_BITS-1:0] sig_q, sig_d;
  logic                  err_q, err_d;

  logic [6:0]            sym;
  logic                  blank;
  logic                  no_room;
  logic [COUNT_BITS:0]   bw_sum;

  assign sym     = sym_lookup(char_code_i);
  assign blank   = (char_code_i inside {[8'h09:8'h0D]}) || (char_code_i == 8'h20);
  assign no_room = (CmpW'(bw_q) + CmpW'(2)) >= CmpW'(cap_q);
  assign bw_sum  = {1'b0, bw_q} + (COUNT_BITS+1)'(3);

  always_comb begin
    acc_d      = acc_q;
    pos_d      = pos_q;
    bw_d       = bw_q;
    sig_d      = sig_q;
    err_d      = err_q;
    push_o     = 1'b0;
    push_job_o = '{is_group: 1'b0, kind: KIND_ERROR, group: acc_q,
                   count: CharCountW'(sig_q)};
    if (in_fire_i) begin
      if (end_of_text_i) begin
        push_o          = 1'b1;
        push_job_o.kind = err_q ? KIND_ERROR : KIND_DONE;
        acc_d           = '0;
        pos_d           = '0;
        bw_d            = '0;
        sig_d           = '0;
        err_d           = 1'b0;
      end else if (err_q) begin
        err_d = 1'b1;
      end else if (no_room || (!blank && !sym[6])) begin
        err_d  = 1'b1;
        push_o = 1'b1;
      end else if (!blank) begin
        acc_d = {acc_q[GroupW-7:0], sym[5:0]};
        sig_d = (sig_q == CntMax) ? sig_q : sig_q + COUNT_BITS'(1);
        if (pos_q == 2'd3) begin
          pos_d               = '0;
          bw_d                = (bw_sum > {1'b0, CntMax}) ? CntMax : bw_sum[COUNT_BITS-1:0];
          push_o              = 1'b1;
          push_job_o.is_group = 1'b1;
          push_job_o.kind     = KIND_BYTE;
          push_job_o.group    = acc_d;
          push_job_o.count    = CharCountW'(sig_d);
        end else begin
          pos_d = pos_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
      acc_q <= '0;
      pos_q <= '0;
      bw_q  <= '0;
      sig_q <= '0;
      err_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      acc_q <= acc_d;
      pos_q <= pos_d;
      bw_q  <= bw_d;
      sig_q <= sig_d;
      err_q <= err_d;
    end
  end

  a_eot_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && end_of_text_i |=> pos_q == 2'd0 && !err_q && sig_q == '0 && bw_q == '0)
    else $error("End of text did not clear the text state.");

  a_err_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && !end_of_text_i && err_q |-> !push_o)
    else $error("A character after an error produced a word.");

endmodule

>>> sv/b64d_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the back end.
module b64d_queue
  import b64d_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output job_t head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t              mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;

  assign full_o  = cnt_q == (PtrW+1)'(QueueDepth);
  assign avail_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("Job pushed into a full queue.");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !avail_o))
    else $error("Job popped from an empty queue.");

endmodule

>>> sv/b64d_back.sv
`timescale 1ns / 1ps
// Back end: turns queued jobs into output words, one word per handshake.
module b64d_back
  import b64d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  job_t        head_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic       busy_q;
  logic [1:0] beat_q;
  job_t       job_q;
  logic       fire;
  logic       is_last;
  logic [7:0] data_byte;

  assign is_last = !job_q.is_group || (beat_q == 2'd2);
  assign fire    = busy_q && m_axis_tready;
  assign pop_o   = avail_i && (!busy_q || (fire && is_last));

  always_comb begin
    case (beat_q)
      2'd0:    data_byte = job_q.group[23:16];
      2'd1:    data_byte = job_q.group[15:8];
      default: data_byte = job_q.group[7:0];
    endcase
    if (!job_q.is_group) begin
      data_byte = 8'd0;
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = {3'd0, job_q.count, data_byte};
  assign m_axis_tuser  = job_q.kind;
  assign m_axis_tlast  = is_last;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= '0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        beat_q <= '0;
      end else if (fire) begin
        if (is_last) begin
          busy_q <= 1'b0;
          beat_q <= '0;
        end else begin
          beat_q <= beat_q + 2'd1;
        end
      end
    end
  end

  a_status_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !job_q.is_group |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
    else $error("Status word not marked last or carries data.");

endmodule

>>> dv/base64_stream_decoder_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench that streams base64 text through the decoder and checks every word.
module base64_stream_decoder_top_test;
  import b64d_pkg::*;

  localparam int unsigned CountMax   = (1 << CountBitsDefault) - 1;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 200;

  typedef struct packed {
    logic [7:0]            data;
    kind_e                 kind;
    logic [CharCountW-1:0] count;
    logic                  last;
  } out_word_t;

  class decode_tracker;
    logic [CapacityW-1:0] capacity;
    logic [GroupW-1:0]    group_bits;
    int unsigned          quartet;
    int unsigned          bytes_out;
    int unsigned          sym_count;
    bit                   text_failed;
    int unsigned          mismatches;
    out_word_t            pending_words[$];

    function new();
      capacity   = CapacityReset;
      mismatches = 0;
      clear_text();
    endfunction

    function void clear_text();
      group_bits  = '0;
      quartet     = 0;
      bytes_out   = 0;
      sym_count   = 0;
      text_failed = 1'b0;
    endfunction

    function void push_word(logic [7:0] data, kind_e kind, logic last);
      out_word_t w;
      w.data  = data;
      w.kind  = kind;
      w.count = CharCountW'(sym_count);
      w.last  = last;
      pending_words.push_back(w);
    endfunction

    function bit char_value(logic [7:0] c, output logic [5:0] v);
      v = '0;
      if (c >= 8'h41 && c <= 8'h5A) v = 6'(c - 8'h41);
      else if (c >= 8'h61 && c <= 8'h7A) v = 6'(c - 8'h61 + 8'd26);
      else if (c >= 8'h30 && c <= 8'h39) v = 6'(c - 8'h30 + 8'd52);
      else if (c == 8'h2B) v = 6'h3E;
      else if (c == 8'h2F) v = 6'h3F;
      else if (c != 8'h3D) return 1'b0;
      return 1'b1;
    endfunction

    function void note_char(logic [7:0] c, logic eot);
      logic [5:0] v;
      if (eot) begin
        push_word(8'h00, text_failed ? KIND_ERROR : KIND_DONE, 1'b1);
        clear_text();
        return;
      end
      if (text_failed) return;
      if (bytes_out + 2 >= capacity) begin
        text_failed = 1'b1;
        push_word(8'h00, KIND_ERROR, 1'b1);
        return;
      end
      if ((c >= 8'h09 && c <= 8'h0D) || c == 8'h20) return;
      if (!char_value(c, v)) begin
        text_failed = 1'b1;
        push_word(8'h00, KIND_ERROR, 1'b1);
        return;
      end
      group_bits = {group_bits[GroupW-7:0], v};
      if (sym_count < CountMax) sym_count++;
      if (quartet == 3) begin
        quartet   = 0;
        bytes_out = (bytes_out + 3 > CountMax) ? CountMax : bytes_out + 3;
        push_word(group_bits[23:16], KIND_BYTE, 1'b0);
        push_word(group_bits[15:8], KIND_BYTE, 1'b0);
        push_word(group_bits[7:0], KIND_BYTE, 1'b1);
      end else begin
        quartet++;
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task check_word(logic [7:0] data, kind_e kind, logic [CharCountW-1:0] count,
                    logic last);
      out_word_t want;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word data %h kind %s count %0d last %b",
                                  data, kind.name(), count, last));
        return;
      end
      want = pending_words.pop_front();
      if (data != want.data)
        report_mismatch($sformatf("data_byte got %h want %h", data, want.data));
      if (kind != want.kind)
        report_mismatch($sformatf("kind got %s want %s", kind.name(), want.kind.name()));
      if (count != want.count)
        report_mismatch($sformatf("char_count got %0d want %0d", count, want.count));
      if (last != want.last)
        report_mismatch($sformatf("last got %b want %b", last, want.last));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CapacityW-1:0] cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [31:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  decode_tracker tracker = new();
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  logic          hold_off;
  int unsigned   quiet_cycles;

  base64_stream_decoder_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= hold_off ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_word(m_axis_tdata[7:0], kind_e'(m_axis_tuser), m_axis_tdata[28:8],
                         m_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("base64_stream_decoder_top_test: done, errors");
      $finish;
    end
  end

  task automatic send_char(logic [7:0] c, logic eot);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_char(c, eot);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CapacityW-1:0] value);
    wait_drained();
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.capacity = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic hold_receiver(int unsigned cycles);
    @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (cycles) @(negedge clk_i);
    hold_off <= 1'b0;
  endtask

  function automatic logic [7:0] pick_symbol();
    int unsigned k;
    k = $urandom_range(0, 64);
    if (k < 26) return 8'(8'h41 + k);
    if (k < 52) return 8'(8'h61 + k - 26);
    if (k < 62) return 8'(8'h30 + k - 52);
    if (k == 62) return 8'h2B;
    if (k == 63) return 8'h2F;
    return 8'h3D;
  endfunction

  function automatic logic [7:0] pick_blank();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? 8'h20 : 8'(8'h09 + k);
  endfunction

  // A text is whole groups plus a short tail, with stray whitespace and at most
  // one arbitrary byte, closed by an end marker.
  task automatic send_random_text(int unsigned groups, bit noisy);
    int unsigned n;
    int          bad_at;
    n = groups * 4 + $urandom_range(0, 3);
    bad_at = noisy ? int'($urandom_range(0, n - 1)) : -1;
    for (int i = 0; i < int'(n); i++) begin
      if ($urandom_range(0, 9) == 0) send_char(pick_blank(), 1'b0);
      if (i == bad_at) send_char(8'($urandom_range(0, 255)), 1'b0);
      else send_char(pick_symbol(), 1'b0);
    end
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic run_texts(int unsigned texts, int unsigned max_groups);
    for (int t = 0; t < int'(texts); t++) begin
      send_random_text($urandom_range(1, max_groups), $urandom_range(0, 3) == 0);
    end
  endtask

  // Bit 8 of each entry marks the end of a text.
  localparam logic [8:0] Directed[21] = '{
    9'h051, 9'h055, 9'h009, 9'h04A, 9'h044,
    9'h02B, 9'h02F, 9'h07A, 9'h039,
    9'h03D, 9'h00D, 9'h061, 9'h05A, 9'h030,
    9'h078, 9'h100,
    9'h0FF, 9'h041, 9'h020, 9'h100,
    9'h1A5
  };

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    hold_off      = 1'b0;
    quiet_cycles  = 0;
    send_idle_pct = 7;
    recv_idle_pct = 54;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (Directed[i]) send_char(Directed[i][7:0], Directed[i][8]);

    write_capacity('0);
    run_texts(1, 1);
    write_capacity(CapacityReset);
    run_texts(2, 2);

    wait_drained();
    send_idle_pct = 54;
    recv_idle_pct <= 7;
    run_texts(2, 2);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    fork
      hold_receiver(HoldCycles);
      send_random_text(5, 1'b0);
    join
    wait_drained();

    write_capacity(CapacityW'($urandom_range(3, 14)));
    run_texts(2, 3);

    write_capacity(CapacityW'($urandom_range(0, 20'hFFFFF)));
    run_texts(1, 3);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("base64_stream_decoder_top_test: done, clean");
    end else begin
      $display("base64_stream_decoder_top_test: done, errors");
    end
    $finish;
  end

endmodule

>>> base64_stream_decoder_top.f
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder_top.sv
dv/base64_stream_decoder_top_test.sv
